// ===== design/sf5_pkg.sv =====
// Constants, types and helpers shared by the separable 5x5 filter.
`timescale 1ns / 1ps

package sf5_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCNT_W     = COL_W + 1;
  localparam int ROW_W      = 17;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int KER_W      = 40;
  localparam int TAP_W      = 8;
  localparam int PIX_W      = 8;
  localparam int NTAPS      = 5;
  localparam int NLINES     = 4;
  localparam int LINE_SEL_W = $clog2(NLINES);
  localparam int VPROD_W    = TAP_W + PIX_W;
  localparam int VSUM_W     = 16;
  localparam int VACC_W     = VPROD_W + 3;
  localparam int HPROD_W    = TAP_W + VSUM_W;
  localparam int HSUM_W     = HPROD_W + 3;

  localparam int APB_AW      = 5;
  localparam int APB_DW      = 64;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = 2;

  localparam logic [FW_W-1:0]  WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0]  HEIGHT_RST = FH_W'(480);
  localparam logic [KER_W-1:0] KER_RST    = KER_W'(65536);

  // pending extra right-border results at a row end
  localparam logic [1:0] EXT_NONE   = 2'd0;
  localparam logic [1:0] EXT_SECOND = 2'd1;
  localparam logic [1:0] EXT_FIRST  = 2'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HKERNEL      = 2'd2,
    REG_VKERNEL      = 2'd3
  } sf5_reg_t;

  typedef logic [NTAPS-1:0][VSUM_W-1:0]  sf5_win_t;
  typedef logic [NTAPS-1:0][VPROD_W-1:0] sf5_vprod_t;
  typedef logic [NTAPS-1:0][HPROD_W-1:0] sf5_hprod_t;

  // per-beat control carried down the pipeline
  typedef struct packed {
    logic col_zero;  // first column: window fills
    logic row_end;   // last input column of the row
    logic e0;        // main result exists
    logic e1;        // first extra result exists
    logic e2;        // second extra result exists
    logic last_row;  // output row is the last one of the frame
  } sf5_flags_t;

  function automatic logic [TAP_W-1:0] ker_tap(input logic [KER_W-1:0] ker, input int i);
    return ker[i*TAP_W +: TAP_W];
  endfunction

  function automatic sf5_win_t shift_win(input sf5_win_t w, input logic [VSUM_W-1:0] v);
    sf5_win_t s;
    for (int i = 0; i < NTAPS - 1; i++) begin
      s[i] = w[i+1];
    end
    s[NTAPS-1] = v;
    return s;
  endfunction

endpackage

// ===== design/separable_filter_5x5_replicate.sv =====
// Top level of the streaming 5x5 separable filter with replicated borders.
// Usage:
//  - Input beats (in_valid/in_ready) carry one grey pixel of the frame in
//    raster order; after the last frame pixel the source sends 2*width drain
//    beats that stand for the replicated bottom rows.
//  - Result beats (out_valid/out_ready) carry filtered pixels in raster
//    order; input (r,c) yields output (r-2,c-2), and the last input of each
//    row also yields the two rightmost columns.
//  - Registers (APB, 64-bit data, byte address 8*i): frame width, frame
//    height, horizontal and vertical kernels, five 8-bit taps each.
//  - Path: a result passes the item, vertical product, vertical sum, window
//    and output registers after its input beat is accepted.
//  - Throughput: one input beat per cycle while the output is not stalled;
//    a row-end beat, once in the window stage, holds the input closed while
//    its extra right-border results are formed there.
//  - Back-pressure: when out_ready is low with a result waiting, the whole
//    pipeline holds and in_ready drops.
//  - Reset (rst_n low at a clock edge) clears the counters and pipeline,
//    and reloads the register defaults. The line stores are not cleared.
`timescale 1ns / 1ps

module separable_filter_5x5_replicate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sf5_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sf5_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  output logic                          out_last_of_run,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sf5_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [sf5_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [sf5_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import sf5_pkg::*;

  // ---------------- configuration registers ----------------
  logic [FW_W-1:0]  width_r;
  logic [FH_W-1:0]  height_r;
  logic [KER_W-1:0] hker_r;
  logic [KER_W-1:0] vker_r;
  sf5_reg_t         cfg_sel;
  logic             cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = sf5_reg_t'(cfg_paddr[REG_IDX_LSB +: REG_IDX_W]);
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      hker_r   <= KER_RST;
      vker_r   <= KER_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  width_r  <= cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_pwdata[FH_W-1:0];
        REG_HKERNEL:      hker_r   <= cfg_pwdata[KER_W-1:0];
        REG_VKERNEL:      vker_r   <= cfg_pwdata[KER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = APB_DW'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(height_r);
      REG_HKERNEL:      cfg_prdata = APB_DW'(hker_r);
      REG_VKERNEL:      cfg_prdata = APB_DW'(vker_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic       out_valid_r;
  logic [1:0] ext_cnt_r;
  logic       adv;
  logic       up_adv;
  logic       accept;

  assign adv      = !out_valid_r || out_ready;
  assign up_adv   = adv && (ext_cnt_r == EXT_NONE);
  assign in_ready = up_adv;
  assign accept   = in_valid && in_ready;

  // ---------------- counters and tap sources ----------------
  logic [ROW_W-1:0]      row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]      col_cnt_r, col_cnt_nxt;
  logic [WCNT_W-1:0]     w_eff;
  logic [FH_W-1:0]       h_eff;
  logic [ROW_W-1:0]      h_plus2;
  logic                  restart;
  logic [ROW_W-1:0]      r_cur;
  logic [COL_W-1:0]      c_cur;
  logic                  row_end;
  logic                  in_frame;
  logic                  out_row_ok;
  sf5_flags_t            flags;
  logic [ROW_W:0]        k_ofs [NTAPS];
  logic [ROW_W-1:0]      k_cl  [NTAPS];
  logic [NTAPS-1:0]      sel_pix;
  logic [LINE_SEL_W-1:0] sel_line [NTAPS];

  always_comb begin
    if (width_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(width_r);
    end
    h_eff   = (height_r == '0) ? FH_W'(1) : height_r;
    h_plus2 = ROW_W'(h_eff) + ROW_W'(2);

    restart = (WCNT_W'(col_cnt_r) >= w_eff) || (row_cnt_r >= h_plus2);
    r_cur   = restart ? '0 : row_cnt_r;
    c_cur   = restart ? '0 : col_cnt_r;

    row_end    = (WCNT_W'(c_cur) == w_eff - WCNT_W'(1));
    in_frame   = (r_cur < ROW_W'(h_eff));
    out_row_ok = (r_cur >= ROW_W'(2));

    flags.col_zero = (c_cur == '0);
    flags.row_end  = row_end;
    flags.e0       = out_row_ok && (c_cur >= COL_W'(2));
    flags.e1       = out_row_ok && row_end && (c_cur >= COL_W'(1));
    flags.e2       = out_row_ok && row_end;
    flags.last_row = (r_cur == h_plus2 - ROW_W'(1));

    if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_cur + ROW_W'(1) >= h_plus2) ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_cnt_nxt = c_cur + COL_W'(1);
      row_cnt_nxt = r_cur;
    end

    // tap i looks at row r-4+i, clamped into the frame; offset by 4 to stay unsigned
    for (int i = 0; i < NTAPS; i++) begin
      k_ofs[i] = (ROW_W+1)'(r_cur) + (ROW_W+1)'(i);
      if (k_ofs[i] < (ROW_W+1)'(NTAPS - 1)) begin
        k_cl[i] = '0;
      end else begin
        k_cl[i] = ROW_W'(k_ofs[i] - (ROW_W+1)'(NTAPS - 1));
      end
      if (k_cl[i] > ROW_W'(h_eff) - ROW_W'(1)) begin
        k_cl[i] = ROW_W'(h_eff) - ROW_W'(1);
      end
      sel_pix[i]  = (k_cl[i] == r_cur);
      sel_line[i] = k_cl[i][LINE_SEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (accept) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // ---------------- line stores: one per row index mod 4 ----------------
  logic [PIX_W-1:0] line_rd [NLINES];

  for (genvar b = 0; b < NLINES; b++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_r;

    // read-before-write: the same column of row r-4 is read as row r lands
    always_ff @(posedge clk) begin
      if (accept) begin
        rd_r <= mem[c_cur];
        if (in_frame && (r_cur[LINE_SEL_W-1:0] == LINE_SEL_W'(b))) begin
          mem[c_cur] <= in_pixel_in;
        end
      end
    end

    assign line_rd[b] = rd_r;
  end

  // ---------------- stage 1: item and store read ----------------
  logic                  s1_v_r;
  logic [PIX_W-1:0]      s1_pix_r;
  logic [NTAPS-1:0]      s1_sel_pix_r;
  logic [LINE_SEL_W-1:0] s1_sel_line_r [NTAPS];
  sf5_flags_t            s1_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (up_adv) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_pixel_in;
      s1_sel_pix_r  <= sel_pix;
      s1_sel_line_r <= sel_line;
      s1_flags_r    <= flags;
    end
  end

  // ---------------- stage 2: vertical products ----------------
  logic             s2_v_r;
  sf5_vprod_t       vprod_r;
  sf5_flags_t       s2_flags_r;
  logic [PIX_W-1:0] vsrc [NTAPS];

  always_comb begin
    for (int i = 0; i < NTAPS; i++) begin
      if (s1_sel_pix_r[i]) begin
        vsrc[i] = s1_pix_r;
      end else begin
        case (s1_sel_line_r[i])
          2'd0:    vsrc[i] = line_rd[0];
          2'd1:    vsrc[i] = line_rd[1];
          2'd2:    vsrc[i] = line_rd[2];
          default: vsrc[i] = line_rd[3];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (up_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv) begin
      for (int i = 0; i < NTAPS; i++) begin
        vprod_r[i] <= VPROD_W'(ker_tap(vker_r, i)) * VPROD_W'(vsrc[i]);
      end
      s2_flags_r <= s1_flags_r;
    end
  end

  // ---------------- stage 3: vertical sum, saturated ----------------
  logic              s3_v_r;
  logic [VSUM_W-1:0] s3_acc_r;
  sf5_flags_t        s3_flags_r;
  logic [VACC_W-1:0] vsum;

  always_comb begin
    vsum = '0;
    for (int i = 0; i < NTAPS; i++) begin
      vsum = vsum + VACC_W'(vprod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (up_adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv) begin
      s3_acc_r   <= (vsum[VACC_W-1:VSUM_W] != '0) ? '1 : vsum[VSUM_W-1:0];
      s3_flags_r <= s2_flags_r;
    end
  end

  // ---------------- stage 4: column window and horizontal products ----------------
  sf5_win_t          win_r, win_nxt;
  logic [VSUM_W-1:0] ext_acc_r;
  logic              ext_e1_r, ext_e2_r, ext_last_row_r;
  logic              w_v_r, w_v_nxt;
  logic              w_row_end_r, w_row_end_nxt;
  logic              w_frame_end_r, w_frame_end_nxt;
  logic              w_last_r, w_last_nxt;
  sf5_hprod_t        hprod_r;

  always_comb begin
    win_nxt         = win_r;
    w_v_nxt         = 1'b0;
    w_row_end_nxt   = 1'b0;
    w_frame_end_nxt = 1'b0;
    w_last_nxt      = 1'b0;
    if (ext_cnt_r != EXT_NONE) begin
      // right border: the last intermediate goes in again
      win_nxt = shift_win(win_r, ext_acc_r);
      if (ext_cnt_r == EXT_FIRST) begin
        w_v_nxt    = ext_e1_r;
        w_last_nxt = ext_e1_r && !ext_e2_r;
      end else begin
        w_v_nxt         = ext_e2_r;
        w_last_nxt      = ext_e2_r;
        w_row_end_nxt   = 1'b1;
        w_frame_end_nxt = ext_last_row_r;
      end
    end else if (s3_v_r) begin
      if (s3_flags_r.col_zero) begin
        for (int i = 0; i < NTAPS; i++) begin
          win_nxt[i] = s3_acc_r;
        end
      end else begin
        win_nxt = shift_win(win_r, s3_acc_r);
      end
      w_v_nxt    = s3_flags_r.e0;
      w_last_nxt = s3_flags_r.e0 && !s3_flags_r.e1 && !s3_flags_r.e2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_cnt_r <= EXT_NONE;
      w_v_r     <= 1'b0;
    end else if (adv) begin
      w_v_r <= w_v_nxt;
      if (ext_cnt_r != EXT_NONE) begin
        ext_cnt_r <= ext_cnt_r - 2'd1;
      end else if (s3_v_r && s3_flags_r.row_end) begin
        ext_cnt_r <= EXT_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r         <= win_nxt;
      w_row_end_r   <= w_row_end_nxt;
      w_frame_end_r <= w_frame_end_nxt;
      w_last_r      <= w_last_nxt;
      for (int i = 0; i < NTAPS; i++) begin
        hprod_r[i] <= HPROD_W'(ker_tap(hker_r, i)) * HPROD_W'(win_nxt[i]);
      end
      if (ext_cnt_r == EXT_NONE) begin
        ext_acc_r      <= s3_acc_r;
        ext_e1_r       <= s3_flags_r.e1;
        ext_e2_r       <= s3_flags_r.e2;
        ext_last_row_r <= s3_flags_r.last_row;
      end
    end
  end

  // ---------------- stage 5: horizontal sum, clamp, output register ----------------
  logic [HSUM_W-1:0] hsum;
  logic [PIX_W-1:0]  pix_r;
  logic              row_end_r, frame_end_r, last_r;

  always_comb begin
    hsum = '0;
    for (int i = 0; i < NTAPS; i++) begin
      hsum = hsum + HSUM_W'(hprod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= w_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r       <= (hsum[HSUM_W-1:PIX_W] != '0) ? '1 : hsum[PIX_W-1:0];
      row_end_r   <= w_row_end_r;
      frame_end_r <= w_frame_end_r;
      last_r      <= w_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = pix_r;
  assign out_row_end     = row_end_r;
  assign out_frame_end   = frame_end_r;
  assign out_last_of_run = last_r;

`ifndef NO_ASSERTIONS
  // input stays closed while the extra border results are being formed
  a_ext_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (ext_cnt_r != EXT_NONE) |-> !in_ready)
    else $error("input taken during right-border extras");

  // extras step down one per advance
  a_ext_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ext_cnt_r == EXT_FIRST) |=> (ext_cnt_r == EXT_SECOND))
    else $error("right-border extra sequence broken");

  // a row end is always the final result of its input beat
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_end) |-> out_last_of_run)
    else $error("row end not last of run");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");
`endif

endmodule
